[hdl/fprm_pkg.sv]
// Shared types and constants for the filtered pulse rate meter.
// No dependencies; imported by every other module of the block.
`timescale 1ns / 1ps

package fprm_pkg;

  // Defaults for the top-level parameters.
  localparam int TIME_BITS_DEF  = 32;
  localparam int COUNT_BITS_DEF = 8;
  localparam int FRAC_BITS_DEF  = 8;

  // Fixed field widths.
  localparam int CFG_W      = 32;
  localparam int CFG_ADDR_W = 2;
  localparam int STAMP_W    = 32;
  localparam int TOTAL_W    = 32;
  localparam int RATE_W     = 42;

  // Stream packing.
  localparam int IN_TDATA_W  = 72;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 80;
  localparam int OUT_TUSER_W = 3;
  localparam int OUT_PAD_W   = OUT_TDATA_W - RATE_W - TOTAL_W;

  // One minute in microseconds, and the bits it needs.
  localparam int unsigned MINUTE_US   = 60_000_000;
  localparam int          MINUTE_BITS = 26;

  localparam logic [CFG_W-1:0]  TIMEOUT_RESET = 32'd60_000_000;
  localparam logic [RATE_W-1:0] RATE_MAX      = '1;

  typedef enum logic [1:0] {
    OP_START     = 2'd0,
    OP_CHANGE    = 2'd1,
    OP_POLL      = 2'd2,
    OP_SET_TOTAL = 2'd3
  } op_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_FILTER_MODE  = 2'd0,
    CFG_FILTER_TIME  = 2'd1,
    CFG_TIMEOUT_TIME = 2'd2,
    CFG_TOTAL_EN     = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_INIT = 2'd0,
    PH_RUN  = 2'd1,
    PH_TOUT = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVENT,
    ST_PEEK,
    ST_TOUT,
    ST_DELTA,
    ST_MUL,
    ST_DIV,
    ST_PUSH
  } state_t;

  typedef struct packed {
    logic               rate_valid;
    logic [RATE_W-1:0]  rate_ppm;
    logic               tout_zero;
    logic               total_valid;
    logic [TOTAL_W-1:0] total_count;
  } res_t;

endpackage

[hdl/fprm_tunit.sv]
// Shared time unit: wrapping difference of two timestamps and its compare to a limit.
// Depends on fprm_pkg; used by fprm_core for every time check of an item.
`timescale 1ns / 1ps

module fprm_tunit
  import fprm_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic [TIME_BITS-1:0] a,
  input  logic [TIME_BITS-1:0] b,
  input  logic [CFG_W-1:0]     lim,
  input  logic                 strict,
  output logic [TIME_BITS-1:0] diff,
  output logic                 hit
);

  localparam int MW = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

  logic [MW-1:0] diff_x;
  logic [MW-1:0] lim_x;

  assign diff   = a - b;
  assign diff_x = MW'(diff);
  assign lim_x  = MW'(lim);
  assign hit    = strict ? (diff_x > lim_x) : (diff_x >= lim_x);

endmodule

[hdl/fprm_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle, saturating at RATE_W bits.
// Depends on fprm_pkg; used by fprm_core for the rate of a poll.
`timescale 1ns / 1ps

module fprm_div
  import fprm_pkg::*;
#(
  parameter int NUM_W = MINUTE_BITS + COUNT_BITS_DEF + FRAC_BITS_DEF,
  parameter int DEN_W = TIME_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  output logic              done,
  output logic [RATE_W-1:0] quo
);

  localparam int CW = $clog2(NUM_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [NUM_W-1:0]  num_r, num_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [RATE_W-1:0] q_r, q_nxt;
  logic              sat_r, sat_nxt;

  logic [DEN_W:0]    rem_sh;
  logic [DEN_W:0]    rem_sub;
  logic              fits;

  // Remainder stays below the divisor, so one extra bit holds the shifted value.
  assign rem_sh  = {rem_r, num_r[NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign fits    = (rem_sh >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    sat_nxt  = sat_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(NUM_W);
      num_nxt  = num;
      den_nxt  = den;
      rem_nxt  = '0;
      q_nxt    = '0;
      sat_nxt  = 1'b0;
    end else if (busy_r) begin
      num_nxt = num_r << 1;
      rem_nxt = fits ? DEN_W'(rem_sub) : DEN_W'(rem_sh);
      q_nxt   = {q_r[RATE_W-2:0], fits};
      sat_nxt = sat_r | q_r[RATE_W-1];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    sat_r <= sat_nxt;
  end

  assign done = done_r;
  assign quo  = sat_r ? RATE_MAX : q_r;

endmodule

[hdl/fprm_core.sv]
// Sequencer and meter state: edge and pulse filtering, early counting, timeout and rate.
// Depends on fprm_pkg, fprm_tunit and fprm_div.
`timescale 1ns / 1ps

module fprm_core
  import fprm_pkg::*;
#(
  parameter int TIME_BITS  = TIME_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  op_t                   in_op,
  input  logic                  in_pin,
  input  logic [STAMP_W-1:0]    in_now,
  input  logic [TOTAL_W-1:0]    in_total,
  output logic                  res_valid,
  input  logic                  res_ready,
  output res_t                  res
);

  localparam int PROD_W = MINUTE_BITS + COUNT_BITS;
  localparam int NUM_W  = PROD_W + FRAC_BITS;
  localparam logic [MINUTE_BITS-1:0] MINUTE_K = MINUTE_BITS'(MINUTE_US);

  // Configuration
  logic               filter_mode_r;
  logic [CFG_W-1:0]   filter_time_r;
  logic [CFG_W-1:0]   timeout_time_r;
  logic               total_en_r;

  // Meter state
  logic                  last_level_r, last_level_nxt;
  logic                  latched_r, latched_nxt;
  logic [TIME_BITS-1:0]  last_event_r, last_event_nxt;
  logic [TIME_BITS-1:0]  last_acc_r, last_acc_nxt;
  logic [TIME_BITS-1:0]  det_edge_r, det_edge_nxt;
  logic [TIME_BITS-1:0]  cand_rise_r, cand_rise_nxt;
  logic [COUNT_BITS-1:0] pending_r, pending_nxt;
  logic                  peeked_r, peeked_nxt;
  logic [TIME_BITS-1:0]  proc_edge_r, proc_edge_nxt;
  phase_t                phase_r, phase_nxt;
  logic [TOTAL_W-1:0]    total_r, total_nxt;

  // Request being worked on
  state_t                state_r, state_nxt;
  op_t                   op_r, op_nxt;
  logic                  pin_r, pin_nxt;
  logic [TIME_BITS-1:0]  now_r, now_nxt;
  logic [TOTAL_W-1:0]    tv_r, tv_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [TIME_BITS-1:0]  pdet_r, pdet_nxt;
  logic [TIME_BITS-1:0]  delta_r, delta_nxt;
  res_t                  res_r, res_nxt;

  // Shared time unit
  logic [TIME_BITS-1:0]  tu_a, tu_b, tu_diff;
  logic [CFG_W-1:0]      tu_lim;
  logic                  tu_strict, tu_hit;

  // Early count decision of a poll
  logic [COUNT_BITS-1:0] pk_cnt;
  logic [TIME_BITS-1:0]  pk_det;
  logic                  pk_flag;

  // Rate divider
  logic                  div_start, div_done;
  logic [PROD_W-1:0]     prod;
  logic [NUM_W-1:0]      div_num;
  logic [RATE_W-1:0]     div_quo;

  fprm_tunit #(
    .TIME_BITS (TIME_BITS)
  ) u_tunit (
    .a      (tu_a),
    .b      (tu_b),
    .lim    (tu_lim),
    .strict (tu_strict),
    .diff   (tu_diff),
    .hit    (tu_hit)
  );

  assign prod    = MINUTE_K * cnt_r;
  assign div_num = NUM_W'(prod) << FRAC_BITS;

  fprm_div #(
    .NUM_W (NUM_W),
    .DEN_W (TIME_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (delta_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  // A debt from an earlier early count is repaid first; then a running high
  // pulse that is already long enough is counted ahead of its falling edge.
  always_comb begin
    pk_cnt  = pending_r;
    pk_flag = peeked_r;
    pk_det  = det_edge_r;
    if (pk_flag && (pk_cnt != '0)) begin
      pk_flag = 1'b0;
      pk_cnt  = pk_cnt - 1'b1;
    end
    if (!pk_flag && (cand_rise_r != det_edge_r) && tu_hit) begin
      pk_flag = 1'b1;
      pk_det  = cand_rise_r;
      pk_cnt  = (&pk_cnt) ? pk_cnt : pk_cnt + 1'b1;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EVENT;
      end
      ST_EVENT: begin
        case (op_r)
          OP_POLL:   state_nxt = ST_PEEK;
          OP_CHANGE: state_nxt = ST_IDLE;
          default:   state_nxt = total_en_r ? ST_PUSH : ST_IDLE;
        endcase
      end
      ST_PEEK: begin
        if (pk_cnt != '0) begin
          if (phase_r == PH_RUN) state_nxt = ST_DELTA;
          else                   state_nxt = total_en_r ? ST_PUSH : ST_IDLE;
        end else if (phase_r == PH_INIT || phase_r == PH_RUN) begin
          state_nxt = ST_TOUT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_TOUT:  state_nxt = tu_hit ? ST_PUSH : ST_IDLE;
      ST_DELTA: state_nxt = (tu_diff == '0) ? ST_PUSH : ST_MUL;
      ST_MUL:   state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_done) state_nxt = ST_PUSH;
      end
      ST_PUSH: begin
        if (res_ready) state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs of each step
  always_comb begin
    logic latched_v;
    last_level_nxt = last_level_r;
    latched_nxt    = latched_r;
    last_event_nxt = last_event_r;
    last_acc_nxt   = last_acc_r;
    det_edge_nxt   = det_edge_r;
    cand_rise_nxt  = cand_rise_r;
    pending_nxt    = pending_r;
    peeked_nxt     = peeked_r;
    proc_edge_nxt  = proc_edge_r;
    phase_nxt      = phase_r;
    total_nxt      = total_r;
    op_nxt         = op_r;
    pin_nxt        = pin_r;
    now_nxt        = now_r;
    tv_nxt         = tv_r;
    cnt_nxt        = cnt_r;
    pdet_nxt       = pdet_r;
    delta_nxt      = delta_r;
    res_nxt        = res_r;
    latched_v      = latched_r;
    tu_a           = now_r;
    tu_b           = filter_mode_r ? last_event_r : last_acc_r;
    tu_lim         = filter_time_r;
    tu_strict      = 1'b0;
    in_ready       = 1'b0;
    res_valid      = 1'b0;
    div_start      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt  = in_op;
          pin_nxt = in_pin;
          now_nxt = TIME_BITS'(in_now);
          tv_nxt  = in_total;
          res_nxt = '0;
        end
      end

      ST_EVENT: begin
        case (op_r)
          OP_START: begin
            last_level_nxt = pin_r;
            proc_edge_nxt  = now_r;
            if (filter_mode_r) latched_nxt = pin_r;
            if (total_en_r) begin
              res_nxt.total_valid = 1'b1;
              res_nxt.total_count = total_r;
            end
          end
          OP_SET_TOTAL: begin
            total_nxt = tv_r;
            if (total_en_r) begin
              res_nxt.total_valid = 1'b1;
              res_nxt.total_count = tv_r;
            end
          end
          default: begin
            // Pin change, or the edge a poll sees that no pin change reported.
            if ((op_r == OP_CHANGE) ? (filter_mode_r || pin_r)
                : (filter_mode_r ? (pin_r != last_level_r) : (pin_r && !last_level_r))) begin
              if (!filter_mode_r) begin
                if (tu_hit) begin
                  last_acc_nxt  = now_r;
                  det_edge_nxt  = now_r;
                  cand_rise_nxt = now_r;
                  pending_nxt   = (&pending_r) ? pending_r : pending_r + 1'b1;
                end
                last_level_nxt = 1'b1;
              end else begin
                if (tu_hit && latched_r && !last_level_r) begin
                  latched_v = 1'b0;
                end else if (tu_hit && !latched_r && last_level_r) begin
                  latched_v    = 1'b1;
                  det_edge_nxt = last_event_r;
                  pending_nxt  = (&pending_r) ? pending_r : pending_r + 1'b1;
                end
                latched_nxt    = latched_v;
                cand_rise_nxt  = (!latched_v && pin_r) ? now_r : det_edge_nxt;
                last_event_nxt = now_r;
                last_level_nxt = pin_r;
              end
            end
            if (op_r == OP_POLL) last_level_nxt = pin_r;
          end
        endcase
      end

      ST_PEEK: begin
        tu_b        = cand_rise_r;
        pending_nxt = '0;
        peeked_nxt  = pk_flag;
        cnt_nxt     = pk_cnt;
        pdet_nxt    = pk_det;
        if (pk_cnt != '0) begin
          if (total_en_r) begin
            total_nxt           = total_r + TOTAL_W'(pk_cnt);
            res_nxt.total_valid = 1'b1;
            res_nxt.total_count = total_r + TOTAL_W'(pk_cnt);
          end
          if (phase_r != PH_RUN) begin
            phase_nxt     = PH_RUN;
            proc_edge_nxt = pk_det;
          end
        end
      end

      ST_TOUT: begin
        tu_b      = proc_edge_r;
        tu_lim    = timeout_time_r;
        tu_strict = 1'b1;
        if (tu_hit) begin
          phase_nxt          = PH_TOUT;
          res_nxt.rate_valid = 1'b1;
          res_nxt.tout_zero  = 1'b1;
        end
      end

      ST_DELTA: begin
        tu_a               = pdet_r;
        tu_b               = proc_edge_r;
        delta_nxt          = tu_diff;
        proc_edge_nxt      = pdet_r;
        res_nxt.rate_valid = 1'b1;
        if (tu_diff == '0) res_nxt.rate_ppm = RATE_MAX;
      end

      ST_MUL: begin
        div_start = 1'b1;
      end

      ST_DIV: begin
        if (div_done) res_nxt.rate_ppm = div_quo;
      end

      ST_PUSH: begin
        res_valid = 1'b1;
      end

      default: ;
    endcase
  end

  assign res = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_mode_r  <= 1'b0;
      filter_time_r  <= '0;
      timeout_time_r <= TIMEOUT_RESET;
      total_en_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_FILTER_MODE:  filter_mode_r  <= cfg_wdata[0];
        CFG_FILTER_TIME:  filter_time_r  <= cfg_wdata;
        CFG_TIMEOUT_TIME: timeout_time_r <= cfg_wdata;
        CFG_TOTAL_EN:     total_en_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      last_level_r <= 1'b0;
      latched_r    <= 1'b0;
      last_event_r <= '0;
      last_acc_r   <= '0;
      det_edge_r   <= '0;
      cand_rise_r  <= '0;
      pending_r    <= '0;
      peeked_r     <= 1'b0;
      proc_edge_r  <= '0;
      phase_r      <= PH_INIT;
      total_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      last_level_r <= last_level_nxt;
      latched_r    <= latched_nxt;
      last_event_r <= last_event_nxt;
      last_acc_r   <= last_acc_nxt;
      det_edge_r   <= det_edge_nxt;
      cand_rise_r  <= cand_rise_nxt;
      pending_r    <= pending_nxt;
      peeked_r     <= peeked_nxt;
      proc_edge_r  <= proc_edge_nxt;
      phase_r      <= phase_nxt;
      total_r      <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    pin_r   <= pin_nxt;
    now_r   <= now_nxt;
    tv_r    <= tv_nxt;
    cnt_r   <= cnt_nxt;
    pdet_r  <= pdet_nxt;
    delta_r <= delta_nxt;
    res_r   <= res_nxt;
  end

endmodule

[hdl/filtered_pulse_rate_meter_top.sv]
// A poll that reports a rate from a nonzero interval gives its result once the bit-serial
// divider has worked through every bit of its numerator.
// One request is in work at a time; a rate poll holds the input until its result is handed over.
// The next request is taken while the previous result waits in the output register.
// Reset: synchronous, active low; clears configuration to its defaults and all meter state.
`timescale 1ns / 1ps

module filtered_pulse_rate_meter_top
  import fprm_pkg::*;
#(
  parameter int TIME_BITS  = TIME_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_W-1:0]       cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // pin_level, now_us, total_value, zero pad
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // opcode
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // rate_ppm, total_count, zero pad
  output logic [OUT_TUSER_W-1:0] out_tuser   // rate_valid, tout_zero, total_valid
);

  logic res_valid, res_ready;
  res_t res;

  logic out_valid_r;
  res_t out_res_r;

  fprm_core #(
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (op_t'(in_tuser)),
    .in_pin    (in_tdata[0]),
    .in_now    (in_tdata[STAMP_W:1]),
    .in_total  (in_tdata[STAMP_W+TOTAL_W:STAMP_W+1]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // The output register frees the core as soon as a result is handed over.
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) out_res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_res_r.total_count, out_res_r.rate_ppm};
  assign out_tuser  = {out_res_r.total_valid, out_res_r.tout_zero, out_res_r.rate_valid};

endmodule
